// ===== src/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Types, constants and wiring tables shared by the rotor cipher unit.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int MAX_SLOTS     = 4;
  localparam int NUM_SEL_REGS  = 4;
  localparam int NUM_WIRINGS   = 9;
  localparam int ALPHA_LEN     = 26;
  localparam int CNT_W         = $clog2(MAX_SLOTS + 1);

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SEL_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd5;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  typedef logic [4:0] letter_t;
  typedef logic [3:0] wiring_t;
  typedef letter_t [ALPHA_LEN-1:0]   lut_row_t;
  typedef lut_row_t [NUM_WIRINGS-1:0] lut_t;

  typedef struct packed {
    logic    decrypt;
    logic    letter;
    letter_t p;
    logic [7:0] raw;
  } item_t;

  typedef struct packed {
    logic    enc_act;
    wiring_t enc_tbl;
    logic    dec_act;
    wiring_t dec_tbl;
    letter_t rot;
  } cell_ctl_t;

  localparam logic [8*ALPHA_LEN-1:0] WIRING_STR [NUM_WIRINGS] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  function automatic lut_t build_fwd();
    lut_t       lut;
    logic [7:0] ch;
    for (int t = 0; t < NUM_WIRINGS; t++) begin
      for (int k = 0; k < ALPHA_LEN; k++) begin
        ch = WIRING_STR[t][8*(ALPHA_LEN-1-k) +: 8];
        lut[t][k] = letter_t'(ch - CHAR_A);
      end
    end
    return lut;
  endfunction

  function automatic lut_t build_inv();
    lut_t fwd;
    lut_t lut;
    fwd = build_fwd();
    lut = '0;
    for (int t = 0; t < NUM_WIRINGS; t++) begin
      for (int k = 0; k < ALPHA_LEN; k++) begin
        lut[t][fwd[t][k]] = letter_t'(k);
      end
    end
    return lut;
  endfunction

  localparam lut_t FWD_LUT = build_fwd();
  localparam lut_t INV_LUT = build_inv();

endpackage

// ===== src/rsc_req_if.sv =====
// ----------------------------------------------------------------------------
// rsc_req_if
// Request channel: request type and character.
// ----------------------------------------------------------------------------
interface rsc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_in;

  modport source (output valid, output req_type, output char_in, input ready);
  modport sink   (input valid, input req_type, input char_in, output ready);
endinterface

// ===== src/rsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rsc_rsp_if
// Response channel: transformed character.
// ----------------------------------------------------------------------------
interface rsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

// ===== src/rsc_cell.sv =====
// ----------------------------------------------------------------------------
// rsc_cell
// One rotor slot: forward or inverse rotated wiring lookup, one register stage.
// ----------------------------------------------------------------------------
module rsc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rsc_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  rsc_pkg::item_t     item_i,
  output logic               valid_o,
  output rsc_pkg::item_t     item_o
);
  import rsc_pkg::*;

  logic           valid_q;
  item_t          item_q, item_d;
  wiring_t        tbl;
  logic           act;
  logic [5:0]     enc_diff, dec_sum;
  letter_t        enc_k, enc_p, dec_k, dec_p;

  always_comb begin
    tbl      = item_i.decrypt ? ctl_i.dec_tbl : ctl_i.enc_tbl;
    act      = item_i.decrypt ? ctl_i.dec_act : ctl_i.enc_act;

    enc_diff = {1'b0, item_i.p} + 6'(ALPHA_LEN) - {1'b0, ctl_i.rot};
    enc_k    = (enc_diff >= 6'(ALPHA_LEN)) ? letter_t'(enc_diff - 6'(ALPHA_LEN))
                                           : enc_diff[4:0];
    enc_p    = FWD_LUT[tbl][enc_k];

    dec_k    = INV_LUT[tbl][item_i.p];
    dec_sum  = {1'b0, dec_k} + {1'b0, ctl_i.rot};
    dec_p    = (dec_sum >= 6'(ALPHA_LEN)) ? letter_t'(dec_sum - 6'(ALPHA_LEN))
                                          : dec_sum[4:0];

    item_d   = item_i;
    if (act && item_i.letter) begin
      item_d.p = item_i.decrypt ? dec_p : enc_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/rotor_substitution_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// rotor_substitution_cipher_unit
// Cascaded rotor substitution cipher, one slot per pipeline cell.
//
//   channel   dir  payload              handshake
//   req_i     in   req_type, char_in    valid / ready
//   rsp_o     out  char_out             valid / ready
//   cfg       in   cfg_idx_i, cfg_wdata_i  cfg_we_i
//
// Each rotor cell registers its result; one request per cycle while the chain advances.
// Each active cell does one rotated table lookup and a mod-26 correction on letters.
// The whole chain advances when the output register is empty or taken.
// Reset clears the config registers and all valid bits.
// ----------------------------------------------------------------------------
module rotor_substitution_cipher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rsc_req_if.sink                        req_i,
  rsc_rsp_if.source                      rsp_o
);
  import rsc_pkg::*;

  wiring_t          sel_q [NUM_SEL_REGS];
  logic [2:0]       count_q;
  logic [4:0]       rot_q;

  letter_t          rot_m;
  logic [CNT_W-1:0] n_act;
  cell_ctl_t        ctl [MAX_SLOTS];

  logic             en;
  logic             valid [MAX_SLOTS+1];
  item_t            item  [MAX_SLOTS+1];
  logic             in_letter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_SEL_REGS; r++) begin
        sel_q[r] <= '0;
      end
      count_q <= '0;
      rot_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEL_A:    sel_q[0] <= cfg_wdata_i[3:0];
        CFG_SEL_B:    sel_q[1] <= cfg_wdata_i[3:0];
        CFG_SEL_C:    sel_q[2] <= cfg_wdata_i[3:0];
        CFG_SEL_D:    sel_q[3] <= cfg_wdata_i[3:0];
        CFG_COUNT:    count_q  <= cfg_wdata_i[2:0];
        CFG_ROTATION: rot_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // unknown selectors and slots without a register use the identity wiring
  function automatic wiring_t pick_sel(input logic [CNT_W-1:0] slot);
    wiring_t s;
    s = '0;
    for (int r = 0; r < NUM_SEL_REGS; r++) begin
      if (int'(slot) == r && int'(sel_q[r]) < NUM_WIRINGS) begin
        s = sel_q[r];
      end
    end
    return s;
  endfunction

  always_comb begin
    rot_m = (rot_q >= 5'(ALPHA_LEN)) ? letter_t'(rot_q - 5'(ALPHA_LEN)) : rot_q;
    n_act = (int'(count_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(count_q);
    for (int j = 0; j < MAX_SLOTS; j++) begin
      ctl[j].enc_act = n_act > CNT_W'(j);
      ctl[j].dec_act = n_act > CNT_W'(j);
      ctl[j].enc_tbl = pick_sel(CNT_W'(j));
      ctl[j].dec_tbl = pick_sel(n_act - CNT_W'(j + 1));
      ctl[j].rot     = rot_m;
    end
  end

  assign en          = !valid[MAX_SLOTS] || rsp_o.ready;
  assign req_i.ready = en;

  assign in_letter        = (req_i.char_in >= CHAR_A) && (req_i.char_in <= CHAR_Z);
  assign valid[0]         = req_i.valid;
  assign item[0].decrypt  = req_i.req_type;
  assign item[0].letter   = in_letter;
  assign item[0].p        = in_letter ? letter_t'(req_i.char_in - CHAR_A) : '0;
  assign item[0].raw      = req_i.char_in;

  for (genvar j = 0; j < MAX_SLOTS; j++) begin : g_cell
    rsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl[j]),
      .valid_i (valid[j]),
      .item_i  (item[j]),
      .valid_o (valid[j+1]),
      .item_o  (item[j+1])
    );
  end

  assign rsp_o.valid    = valid[MAX_SLOTS];
  assign rsp_o.char_out = item[MAX_SLOTS].letter ? ({3'b000, item[MAX_SLOTS].p} + CHAR_A)
                                                 : item[MAX_SLOTS].raw;

endmodule
